// ===== rtl/core/mtwc_pkg.sv =====
// Package: shared types, constants and helpers for the MESI two-way cache controller
`timescale 1ns / 1ps
`default_nettype none
package mtwc_pkg;
    localparam int NUM_SETS_DEF = 8;
    localparam int NUM_WAYS_DEF = 2;
    localparam int ADDR_W = 13;
    localparam int TAG_W = 8;
    localparam int LINE_W = 32;
    localparam int HALF_W = 16;
    localparam int KIND_W = 3;
    localparam int ID_W = 2;

    localparam logic [2:0] K_RD = 3'd0;
    localparam logic [2:0] K_WR = 3'd1;
    localparam logic [2:0] K_SRM = 3'd2;
    localparam logic [2:0] K_SWM = 3'd3;
    localparam logic [2:0] K_SINV = 3'd4;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_S = 2'd1;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    localparam logic [1:0] BR_NONE = 2'd0;
    localparam logic [1:0] BR_RM = 2'd1;
    localparam logic [1:0] BR_WM = 2'd2;
    localparam logic [1:0] BR_INV = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] address;
        logic [1:0]  src_core;
        logic [15:0] wr_half;
        logic [31:0] fill_data;
        logic        peer_shared;
        logic [31:0] peer_data;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [15:0] rd_half;
        logic [1:0]  bus_request;
        logic        writeback_valid;
        logic [12:0] writeback_address;
        logic [31:0] writeback_data;
        logic        snoop_shared;
        logic [31:0] snoop_data;
    } t_rsp;

    // classified request from the front end
    typedef struct packed {
        logic        is_cpu;
        logic        is_snoop;
        t_req        req;
    } t_cmd;

    function automatic logic [15:0] half_read(input logic [31:0] line, input logic [1:0] off);
        logic [31:0] s;
        s = line >> {off, 3'b000};
        return s[15:0];
    endfunction

    function automatic logic [31:0] half_write(input logic [31:0] line, input logic [1:0] off,
                                               input logic [15:0] val);
        logic [31:0] m;
        logic [31:0] v;
        m = 32'h0000_FFFF << {off, 3'b000};
        v = {16'h0000, val} << {off, 3'b000};
        return (line & ~m) | v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mtwc_if.sv =====
// Interfaces: valid/ready channels for requests, responses and configuration
`timescale 1ns / 1ps
`default_nettype none
interface mtwc_req_if;
    logic          valid;
    logic          ready;
    mtwc_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mtwc_rsp_if;
    logic          valid;
    logic          ready;
    mtwc_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mtwc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtwc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read
`timescale 1ns / 1ps
`default_nettype none
module mtwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/mtwc_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end
`timescale 1ns / 1ps
`default_nettype none
module mtwc_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mtwc_req_if.sink         req,
    input  wire logic        i_pop,
    output logic             o_cmd_valid,
    output mtwc_pkg::t_cmd   o_cmd
);
    mtwc_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    mtwc_pkg::t_cmd n_cmd;
    logic           push, pop;

    assign req.ready = (r_cnt != 2'd2);
    assign push = req.valid && req.ready;
    assign pop = i_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];

    always_comb begin
        n_cmd.req = req.payload;
        n_cmd.is_cpu = (req.payload.kind == mtwc_pkg::K_RD) ||
                       (req.payload.kind == mtwc_pkg::K_WR);
        n_cmd.is_snoop = (req.payload.kind == mtwc_pkg::K_SRM) ||
                         (req.payload.kind == mtwc_pkg::K_SWM) ||
                         (req.payload.kind == mtwc_pkg::K_SINV);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/mtwc_back.sv =====
// Back end: set lookup, MESI update and response register
`timescale 1ns / 1ps
`default_nettype none
module mtwc_back #(
    parameter int NUM_SETS = mtwc_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = mtwc_pkg::NUM_WAYS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  wire mtwc_pkg::t_cmd i_cmd,
    output logic            o_pop,
    input  wire logic [1:0] i_own_id,
    mtwc_rsp_if.source      rsp
);
    localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int OFF_W = 2;
    localparam int LINE_AW = mtwc_pkg::ADDR_W - OFF_W;
    localparam int ENT_W = mtwc_pkg::TAG_W + mtwc_pkg::LINE_W + 2;
    localparam int SET_BITS = ENT_W * NUM_WAYS;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;
    // line / NUM_SETS by reciprocal multiply, exact for every line address
    localparam int DIV_SH = LINE_AW + $clog2(NUM_SETS);
    localparam longint DIV_M = ((longint'(1) << DIV_SH) + longint'(NUM_SETS) - 1) /
                               longint'(NUM_SETS);
    localparam logic [LINE_AW:0] DIV_MUL = (LINE_AW+1)'(DIV_M);
    localparam logic [LINE_AW-1:0] SETS_L = LINE_AW'(NUM_SETS);

    logic [1:0]     r_st, n_st;
    mtwc_pkg::t_cmd r_cmd;
    logic [NUM_SETS-1:0] r_valid;
    logic [NUM_SETS-1:0] r_lru;
    logic [SET_BITS-1:0] rd_set, wr_set;
    logic           we;
    mtwc_pkg::t_rsp r_rsp, n_rsp;
    logic           r_rsp_v;

    logic [LINE_AW-1:0] line_a, c_line;
    logic [SET_W-1:0]   set_i, c_set;
    logic [mtwc_pkg::TAG_W-1:0] tag_i;
    logic [1:0]   off;

    function automatic logic [LINE_AW-1:0] line_quot(input logic [LINE_AW-1:0] ln);
        logic [2*LINE_AW:0] p;
        p = (2*LINE_AW+1)'(ln) * (2*LINE_AW+1)'(DIV_MUL);
        return LINE_AW'(p >> DIV_SH);
    endfunction

    function automatic logic [SET_W-1:0] line_set(input logic [LINE_AW-1:0] ln);
        logic [LINE_AW-1:0] r;
        r = ln - line_quot(ln) * SETS_L;
        return SET_W'(r);
    endfunction

    assign line_a = i_cmd.req.address[mtwc_pkg::ADDR_W-1:OFF_W];
    assign set_i = line_set(line_a);
    assign c_line = r_cmd.req.address[mtwc_pkg::ADDR_W-1:OFF_W];
    assign c_set = line_set(c_line);
    assign tag_i = mtwc_pkg::TAG_W'(line_quot(c_line));
    assign off = r_cmd.req.address[1:0];

    mtwc_ram #(.WIDTH(SET_BITS), .DEPTH(NUM_SETS)) u_set_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(c_set), .i_wdata(wr_set),
        .i_raddr(set_i), .o_rdata(rd_set)
    );

    assign o_pop = (r_st == S_IDLE) && i_cmd_valid;
    assign rsp.valid = r_rsp_v;
    assign rsp.payload = r_rsp;

    logic [mtwc_pkg::TAG_W-1:0]  tg [2];
    logic [mtwc_pkg::LINE_W-1:0] dt [2];
    logic [1:0]                  ms [2];
    logic [mtwc_pkg::TAG_W-1:0]  ntg [2];
    logic [mtwc_pkg::LINE_W-1:0] ndt [2];
    logic [1:0]                  nms [2];
    logic        m0, m1, hitw, found, v, lru_n, lru_we;
    logic [mtwc_pkg::LINE_W-1:0] nl;

    function automatic logic [12:0] laddr(input logic [7:0] t, input logic [SET_W-1:0] s);
        logic [31:0] a;
        a = ((32'(t) * 32'(NUM_SETS)) + 32'(s)) << 2;
        return a[12:0];
    endfunction

    always_comb begin
        for (int w = 0; w < 2; w++) begin
            if (r_valid[c_set]) begin
                {tg[w], dt[w], ms[w]} = rd_set[w*ENT_W +: ENT_W];
            end else begin
                tg[w] = '0; dt[w] = '0; ms[w] = mtwc_pkg::ST_I;
            end
            ntg[w] = tg[w]; ndt[w] = dt[w]; nms[w] = ms[w];
        end
        m0 = (ms[0] != mtwc_pkg::ST_I) && (tg[0] == tag_i);
        m1 = (ms[1] != mtwc_pkg::ST_I) && (tg[1] == tag_i);
        found = m0 || m1;
        hitw = !m0;
        n_rsp = '0;
        lru_n = r_lru[c_set];
        lru_we = 1'b0;
        nl = '0;
        if (ms[0] == mtwc_pkg::ST_I) v = 1'b0;
        else if (ms[1] == mtwc_pkg::ST_I) v = 1'b1;
        else v = r_lru[c_set];
        if (r_cmd.is_cpu) begin
            lru_we = 1'b1;
            if (found) begin
                n_rsp.hit = 1'b1;
                lru_n = ~hitw;
                if (r_cmd.req.kind == mtwc_pkg::K_RD) begin
                    n_rsp.rd_half = mtwc_pkg::half_read(dt[hitw], off);
                end else begin
                    if (ms[hitw] == mtwc_pkg::ST_S) n_rsp.bus_request = mtwc_pkg::BR_INV;
                    nms[hitw] = mtwc_pkg::ST_M;
                    ndt[hitw] = mtwc_pkg::half_write(dt[hitw], off, r_cmd.req.wr_half);
                end
            end else begin
                lru_n = ~v;
                if (ms[v] == mtwc_pkg::ST_M) begin
                    n_rsp.writeback_valid = 1'b1;
                    n_rsp.writeback_address = laddr(tg[v], c_set);
                    n_rsp.writeback_data = dt[v];
                end
                ntg[v] = tag_i;
                if (r_cmd.req.kind == mtwc_pkg::K_RD) begin
                    n_rsp.bus_request = mtwc_pkg::BR_RM;
                    nl = r_cmd.req.peer_shared ? r_cmd.req.peer_data : r_cmd.req.fill_data;
                    nms[v] = r_cmd.req.peer_shared ? mtwc_pkg::ST_S : mtwc_pkg::ST_E;
                    ndt[v] = nl;
                    n_rsp.rd_half = mtwc_pkg::half_read(nl, off);
                end else begin
                    n_rsp.bus_request = mtwc_pkg::BR_WM;
                    nms[v] = mtwc_pkg::ST_M;
                    ndt[v] = mtwc_pkg::half_write(r_cmd.req.fill_data, off,
                                                  r_cmd.req.wr_half);
                end
            end
        end else if (r_cmd.is_snoop && (r_cmd.req.src_core != i_own_id) && found) begin
            case (r_cmd.req.kind)
                mtwc_pkg::K_SRM: begin
                    if (ms[hitw] == mtwc_pkg::ST_M) begin
                        n_rsp.writeback_valid = 1'b1;
                        n_rsp.writeback_address = laddr(tag_i, c_set);
                        n_rsp.writeback_data = dt[hitw];
                    end
                    nms[hitw] = mtwc_pkg::ST_S;
                    n_rsp.snoop_shared = 1'b1;
                    n_rsp.snoop_data = dt[hitw];
                end
                mtwc_pkg::K_SWM: begin
                    if (ms[hitw] == mtwc_pkg::ST_M) begin
                        n_rsp.writeback_valid = 1'b1;
                        n_rsp.writeback_address = laddr(tag_i, c_set);
                        n_rsp.writeback_data = dt[hitw];
                    end
                    nms[hitw] = mtwc_pkg::ST_I;
                end
                default: nms[hitw] = mtwc_pkg::ST_I;
            endcase
        end
        for (int w = 0; w < 2; w++) begin
            wr_set[w*ENT_W +: ENT_W] = {ntg[w], ndt[w], nms[w]};
        end
    end

    assign we = (r_st == S_LOOK);

    always_comb begin
        case (r_st)
            S_IDLE: n_st = i_cmd_valid ? S_LOOK : S_IDLE;
            S_LOOK: n_st = S_OUT;
            S_OUT: n_st = (!r_rsp_v || rsp.ready) ? S_IDLE : S_OUT;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        if (we) r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_valid <= '0;
            r_lru <= '0;
            r_rsp_v <= 1'b0;
        end else begin
            r_st <= n_st;
            if (we) begin
                r_valid[c_set] <= 1'b1;
                if (lru_we) r_lru[c_set] <= lru_n;
            end
            if (we) r_rsp_v <= 1'b1;
            else if (rsp.ready) r_rsp_v <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/mesi_two_way_cache_controller.sv =====
// Top level: MESI two-way snooping cache controller
`timescale 1ns / 1ps
`default_nettype none
// Two-way set-associative MESI cache with per-set LRU. Requests (cpu reads and
// writes, snooped read miss, write miss, invalidate) pass through a two-entry
// queue to a back end that reads the set from RAM, updates it and writes it
// back; each transaction produces one response. The back end handles a
// transaction in three steps (set RAM read, update and write, response
// handoff), set by the read-modify-write of the set RAM. No clearing pass:
// per-set valid bits make unwritten sets read as invalid. own_core_id must be
// written on the cfg channel only while idle; the block does not enforce it.
module mesi_two_way_cache_controller #(
    parameter int NUM_SETS = mtwc_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS = mtwc_pkg::NUM_WAYS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mtwc_req_if.sink  req,
    mtwc_rsp_if.source rsp,
    mtwc_cfg_if.sink  cfg
);
    logic           cmd_valid, pop;
    mtwc_pkg::t_cmd cmd;
    logic [1:0]     r_own_id;

    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_own_id <= 2'd0;
        else if (cfg.valid) r_own_id <= cfg.data;
    end

    mtwc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .i_pop(pop),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd)
    );

    mtwc_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_pop(pop), .i_own_id(r_own_id), .rsp(rsp)
    );
endmodule
`default_nettype wire

// ===== rtl/core/mtwc_checker.sv =====
// Checker: port-level assertions for the cache controller, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module mtwc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire mtwc_pkg::t_rsp rsp_payload
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
        else $error("response dropped while stalled");
    a_snoop_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_payload.snoop_shared |-> !rsp_payload.hit)
        else $error("snoop reply with hit");
    a_wb_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_payload.writeback_valid |-> rsp_payload.writeback_address[1:0] == 2'b00)
        else $error("writeback address not aligned");
    a_rm_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_payload.bus_request == mtwc_pkg::BR_RM |-> !rsp_payload.hit)
        else $error("read miss request on hit");
endmodule

bind mesi_two_way_cache_controller mtwc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_payload(rsp.payload)
);
`default_nettype wire
